>>> sv/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon crossing test: vertex
// storage geometry, arithmetic widths, register map and sequencer codes.
// ----------------------------------------------------------------------------
package pip_pkg;

    localparam int VERTEX_DEPTH = 64;
    localparam int ADDR_W       = 6;
    localparam int COUNT_W      = 7;
    localparam int COORD_W      = 32;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int STEP_W       = 3;

    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] REG_RAY_END_X    = 2'd1;
    localparam logic [1:0] REG_RAY_END_Y    = 2'd2;

    localparam logic [COUNT_W-1:0] RESET_VERTEX_COUNT = 7'd4;
    localparam logic signed [COORD_W-1:0] RESET_RAY_END = 32'sd16000000;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Multiplier schedule of one edge: six products, then a drain step.
    localparam logic [STEP_W-1:0] STEP_DEN_P = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DEN_Q = 3'd1;
    localparam logic [STEP_W-1:0] STEP_TN_P  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_TN_Q  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_UN_P  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_UN_Q  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd6;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } vertex_t;

    typedef struct packed {
        logic                load_e;
        logic                load_a;
        logic                load_edge;
        logic                mul_en;
        logic [STEP_W-1:0]   step;
    } xu_ctl_t;

    typedef struct packed {
        logic den_zero;
        logic crosses;
    } edge_res_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FIRST = 6'b000010,
        ST_FETCH = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_EVAL  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

>>> sv/pip_vertex_mem.sv
// ----------------------------------------------------------------------------
// pip_vertex_mem
// Polygon vertex storage with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pip_vertex_mem
    import pip_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  vertex_t           wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output vertex_t           rd_data
);

    vertex_t mem [VERTEX_DEPTH];
    vertex_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/pip_cfg_regs.sv
// ----------------------------------------------------------------------------
// pip_cfg_regs
// APB register file holding the vertex count and the far ray endpoint.
// ----------------------------------------------------------------------------
module pip_cfg_regs
    import pip_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,
    output logic [COUNT_W-1:0]        vertex_count,
    output logic signed [COORD_W-1:0] ray_end_x,
    output logic signed [COORD_W-1:0] ray_end_y
);

    logic [COUNT_W-1:0]        vertex_count_reg;
    logic signed [COORD_W-1:0] ray_end_x_reg;
    logic signed [COORD_W-1:0] ray_end_y_reg;
    logic [1:0]                reg_idx;
    logic                      wr_strobe;

    assign reg_idx   = paddr[3:2];
    assign wr_strobe = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= RESET_VERTEX_COUNT;
            ray_end_x_reg    <= RESET_RAY_END;
            ray_end_y_reg    <= RESET_RAY_END;
        end
        else if (wr_strobe)
        begin
            case (reg_idx)
                REG_VERTEX_COUNT: vertex_count_reg <= pwdata[COUNT_W-1:0];
                REG_RAY_END_X:    ray_end_x_reg    <= $signed(pwdata[COORD_W-1:0]);
                REG_RAY_END_Y:    ray_end_y_reg    <= $signed(pwdata[COORD_W-1:0]);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_VERTEX_COUNT: prdata = APB_DATA_W'(vertex_count_reg);
            REG_RAY_END_X:    prdata = APB_DATA_W'(ray_end_x_reg);
            REG_RAY_END_Y:    prdata = APB_DATA_W'(ray_end_y_reg);
            default:          prdata = '0;
        endcase
    end

    assign vertex_count = vertex_count_reg;
    assign ray_end_x    = ray_end_x_reg;
    assign ray_end_y    = ray_end_y_reg;

endmodule

>>> sv/pip_cross_unit.sv
// ----------------------------------------------------------------------------
// pip_cross_unit
// Shared signed multiplier that forms the three cross products of one edge
// over seven steps and judges whether the edge crosses the ray segment.
// ----------------------------------------------------------------------------
module pip_cross_unit
    import pip_pkg::*;
(
    input  logic                      clk,
    input  xu_ctl_t                   ctl,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] ray_end_x,
    input  logic signed [COORD_W-1:0] ray_end_y,
    input  vertex_t                   vtx,
    output edge_res_t                 res
);

    logic signed [DIFF_W-1:0]  ex_reg;
    logic signed [DIFF_W-1:0]  ey_reg;
    logic signed [DIFF_W-1:0]  dx_reg;
    logic signed [DIFF_W-1:0]  dy_reg;
    logic signed [DIFF_W-1:0]  rx_reg;
    logic signed [DIFF_W-1:0]  ry_reg;
    logic signed [COORD_W-1:0] ax_reg;
    logic signed [COORD_W-1:0] ay_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  hold_reg;
    logic signed [CROSS_W-1:0] den_reg;
    logic signed [CROSS_W-1:0] tn_reg;
    logic signed [CROSS_W-1:0] un_reg;
    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  ext_a;
    logic signed [PROD_W-1:0]  ext_b;
    logic signed [CROSS_W-1:0] diff;

    function automatic logic in_unit(input logic signed [CROSS_W-1:0] num,
                                     input logic signed [CROSS_W-1:0] den);
        logic ok;
        if (!den[CROSS_W-1])
        begin
            ok = !num[CROSS_W-1] && (num < den);
        end
        else
        begin
            ok = (num[CROSS_W-1] || (num == '0)) && (den < num);
        end
        return ok;
    endfunction

    always_comb
    begin
        case (ctl.step)
            STEP_DEN_P:
            begin
                mul_a = dx_reg;
                mul_b = ey_reg;
            end
            STEP_DEN_Q:
            begin
                mul_a = dy_reg;
                mul_b = ex_reg;
            end
            STEP_TN_P:
            begin
                mul_a = ex_reg;
                mul_b = ry_reg;
            end
            STEP_TN_Q:
            begin
                mul_a = rx_reg;
                mul_b = ey_reg;
            end
            STEP_UN_P:
            begin
                mul_a = dx_reg;
                mul_b = ry_reg;
            end
            STEP_UN_Q:
            begin
                mul_a = dy_reg;
                mul_b = rx_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign ext_a = PROD_W'(mul_a);
    assign ext_b = PROD_W'(mul_b);
    assign diff  = CROSS_W'(hold_reg) - CROSS_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.load_e)
        begin
            ex_reg <= DIFF_W'(coord_x) - DIFF_W'(ray_end_x);
            ey_reg <= DIFF_W'(coord_y) - DIFF_W'(ray_end_y);
        end
        if (ctl.load_a)
        begin
            ax_reg <= vtx.x;
            ay_reg <= vtx.y;
        end
        if (ctl.load_edge)
        begin
            dx_reg <= DIFF_W'(vtx.x) - DIFF_W'(ax_reg);
            dy_reg <= DIFF_W'(vtx.y) - DIFF_W'(ay_reg);
            rx_reg <= DIFF_W'(ax_reg) - DIFF_W'(ray_end_x);
            ry_reg <= DIFF_W'(ay_reg) - DIFF_W'(ray_end_y);
            ax_reg <= vtx.x;
            ay_reg <= vtx.y;
        end
        if (ctl.mul_en)
        begin
            prod_reg <= ext_a * ext_b;
            case (ctl.step)
                STEP_DEN_Q: hold_reg <= prod_reg;
                STEP_TN_P:  den_reg  <= diff;
                STEP_TN_Q:  hold_reg <= prod_reg;
                STEP_UN_P:  tn_reg   <= diff;
                STEP_UN_Q:  hold_reg <= prod_reg;
                STEP_DRAIN: un_reg   <= diff;
                default:    ;
            endcase
        end
    end

    assign res.den_zero = (den_reg == '0);
    assign res.crosses  = in_unit(tn_reg, den_reg) && in_unit(un_reg, den_reg);

endmodule

>>> sv/point_in_polygon_crossing_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_crossing_test
// Ray-casting point-in-polygon test over a stored polygon of up to 64
// vertices, with an APB port for the vertex count and the far ray endpoint.
// ----------------------------------------------------------------------------
// A vertex write beat (mode 0) is stored and gives no result. A query beat
// (mode 1) walks all N = min(vertex_count, 64) edges through one shared 33
// by 33 bit multiplier that forms six products per edge, so the block
// stalls its input through the walk until it offers one result beat; a
// query with N of zero goes straight to the done state. The result waits in
// an output register, and vertex writes are taken while it waits. When any
// edge is parallel to the ray, degenerate is high and inside_res is low, and
// software should pick another ray endpoint and repeat the query.
module point_in_polygon_crossing_test
    import pip_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0]     pwdata,
    output logic [APB_DATA_W-1:0]     prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      mode,
    input  logic [ADDR_W-1:0]         vertex_index,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      inside_res,
    output logic                      degenerate
);

    logic [COUNT_W-1:0]        vertex_count;
    logic signed [COORD_W-1:0] ray_end_x;
    logic signed [COORD_W-1:0] ray_end_y;

    state_t              state_reg;
    state_t              state_next;
    logic [ADDR_W-1:0]   edge_idx_reg;
    logic [ADDR_W-1:0]   edge_idx_next;
    logic [ADDR_W-1:0]   next_idx_reg;
    logic [ADDR_W-1:0]   next_idx_next;
    logic [COUNT_W-1:0]  n_reg;
    logic [COUNT_W-1:0]  n_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                parity_reg;
    logic                parity_next;
    logic                degen_reg;
    logic                degen_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                inside_reg;
    logic                inside_next;
    logic                degen_out_reg;
    logic                degen_out_next;

    logic                accept;
    logic                query_go;
    logic                vertex_wr;
    logic [COUNT_W-1:0]  n_calc;
    logic [COUNT_W-1:0]  idx_plus2;
    logic [ADDR_W-1:0]   idx_after;
    logic [ADDR_W-1:0]   rd_addr;
    logic                last_edge;
    logic                out_free;
    vertex_t             wr_vtx;
    vertex_t             rd_vtx;
    xu_ctl_t             xu_ctl;
    edge_res_t           edge_res;

    pip_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .vertex_count (vertex_count),
        .ray_end_x    (ray_end_x),
        .ray_end_y    (ray_end_y)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign vertex_wr = accept && (mode == MODE_WRITE);
    assign query_go  = accept && (mode == MODE_QUERY);

    assign n_calc = (vertex_count > COUNT_W'(VERTEX_DEPTH))
                  ? COUNT_W'(VERTEX_DEPTH) : vertex_count;

    assign idx_plus2 = COUNT_W'(edge_idx_reg) + COUNT_W'(2);
    assign idx_after = (idx_plus2 == n_reg) ? '0 : idx_plus2[ADDR_W-1:0];
    assign last_edge = (COUNT_W'(edge_idx_reg) == (n_reg - COUNT_W'(1)));
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (state_reg)
            ST_IDLE: rd_addr = '0;
            ST_EVAL: rd_addr = idx_after;
            default: rd_addr = next_idx_reg;
        endcase
    end

    assign wr_vtx.x = coord_x;
    assign wr_vtx.y = coord_y;

    pip_vertex_mem u_mem (
        .clk     (clk),
        .wr_en   (vertex_wr),
        .wr_addr (vertex_index),
        .wr_data (wr_vtx),
        .rd_addr (rd_addr),
        .rd_data (rd_vtx)
    );

    assign xu_ctl.load_e    = query_go;
    assign xu_ctl.load_a    = (state_reg == ST_FIRST);
    assign xu_ctl.load_edge = (state_reg == ST_FETCH);
    assign xu_ctl.mul_en    = (state_reg == ST_MUL);
    assign xu_ctl.step      = step_reg;

    pip_cross_unit u_xu (
        .clk       (clk),
        .ctl       (xu_ctl),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .ray_end_x (ray_end_x),
        .ray_end_y (ray_end_y),
        .vtx       (rd_vtx),
        .res       (edge_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        edge_idx_next  = edge_idx_reg;
        next_idx_next  = next_idx_reg;
        n_next         = n_reg;
        step_next      = step_reg;
        parity_next    = parity_reg;
        degen_next     = degen_reg;
        out_valid_next = out_valid_reg && out_stall;
        inside_next    = inside_reg;
        degen_out_next = degen_out_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    n_next        = n_calc;
                    edge_idx_next = '0;
                    next_idx_next = (n_calc == COUNT_W'(1)) ? '0 : ADDR_W'(1);
                    parity_next   = 1'b0;
                    degen_next    = 1'b0;
                    state_next    = (n_calc == '0) ? ST_DONE : ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                step_next  = STEP_DEN_P;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (step_reg == STEP_DRAIN)
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_EVAL:
            begin
                if (edge_res.den_zero)
                begin
                    degen_next = 1'b1;
                end
                else if (edge_res.crosses)
                begin
                    parity_next = !parity_reg;
                end
                if (last_edge)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    edge_idx_next = edge_idx_reg + ADDR_W'(1);
                    next_idx_next = idx_after;
                    state_next    = ST_FETCH;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    inside_next    = parity_reg && !degen_reg;
                    degen_out_next = degen_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            edge_idx_reg  <= '0;
            next_idx_reg  <= '0;
            n_reg         <= '0;
            step_reg      <= '0;
            parity_reg    <= 1'b0;
            degen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            edge_idx_reg  <= edge_idx_next;
            next_idx_reg  <= next_idx_next;
            n_reg         <= n_next;
            step_reg      <= step_next;
            parity_reg    <= parity_next;
            degen_reg     <= degen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg    <= inside_next;
        degen_out_reg <= degen_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;
    assign degenerate = degen_out_reg;

`ifndef SYNTHESIS
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(inside_res && degenerate))
        else $error("inside_res and degenerate both set on a result beat");

    a_edge_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH || state_reg == ST_MUL || state_reg == ST_EVAL)
        |-> (COUNT_W'(edge_idx_reg) < n_reg))
        else $error("edge index ran past the vertex count");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the done state");

    a_step_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> $past(state_reg == ST_MUL && step_reg == STEP_DRAIN))
        else $error("edge evaluated before the product schedule finished");
`endif

endmodule
